FILE: design/ctu_pkg.sv
// ----------------------------------------------------------------------------
// ctu_pkg: shared types and constants of the code-page to utf-8 transcoder
// holds the queue entry format and the code-page to code-point table
// ----------------------------------------------------------------------------
package ctu_pkg;

   localparam logic [7:0] CH_LF = 8'h0A;
   localparam logic [7:0] CH_CR = 8'h0D;

   // what the back end emits after an optional leading lf
   typedef enum logic [1:0] {
      BODY_NONE,
      BODY_BYTE,
      BODY_LOOKUP
   } body_kind_type;

   // one classified item, as it travels from front to back
   typedef struct packed {
      logic          pre_lf;
      body_kind_type kind;
      logic [7:0]    value;
      logic          eot;
   } ctu_entry_type;

   // front status seen by the top level
   typedef struct packed {
      logic held_cr;
   } front_status_type;

   // code points of bytes 128..255
   localparam logic [15:0] CODE_POINTS [0:127] = '{
      16'h00C7, 16'h00FC, 16'h00E9, 16'h00E2, 16'h00E4, 16'h00E0, 16'h00E5, 16'h00E7,
      16'h00EA, 16'h00EB, 16'h00E8, 16'h00EF, 16'h00EE, 16'h00EC, 16'h00C4, 16'h00C5,
      16'h00C9, 16'h00E6, 16'h00C6, 16'h00F4, 16'h00F6, 16'h00F2, 16'h00FB, 16'h00F9,
      16'h00FF, 16'h00D6, 16'h00DC, 16'h00A2, 16'h00A3, 16'h00A5, 16'h00DF, 16'h0192,
      16'h00E1, 16'h00ED, 16'h00F3, 16'h00FA, 16'h00F1, 16'h00D1, 16'h00AA, 16'h00BA,
      16'h00BF, 16'h2310, 16'h00AC, 16'h00BD, 16'h00BC, 16'h00A1, 16'h00AB, 16'h00BB,
      16'h00E3, 16'h00F5, 16'h00D8, 16'h00F8, 16'h0153, 16'h0152, 16'h00C0, 16'h00C3,
      16'h00D5, 16'h00A8, 16'h00B4, 16'h2020, 16'h00B6, 16'h00A9, 16'h00AE, 16'h2122,
      16'h0133, 16'h0132, 16'h005F, 16'h005F, 16'h005F, 16'h005F, 16'h005F, 16'h005F,
      16'h005F, 16'h005F, 16'h005F, 16'h005F, 16'h005F, 16'h005F, 16'h005F, 16'h005F,
      16'h005F, 16'h005F, 16'h005F, 16'h005F, 16'h005F, 16'h005F, 16'h005F, 16'h005F,
      16'h005F, 16'h005F, 16'h005F, 16'h005F, 16'h005F, 16'h00A7, 16'h2227, 16'h221E,
      16'h03B1, 16'h03B2, 16'h0393, 16'h03C0, 16'h03A3, 16'h03C3, 16'h00B5, 16'h03C4,
      16'h03A6, 16'h0398, 16'h03A9, 16'h03B4, 16'h222E, 16'h03C6, 16'h2208, 16'h2229,
      16'h2261, 16'h00B1, 16'h2265, 16'h2264, 16'h2320, 16'h2321, 16'h00F7, 16'h2248,
      16'h00B0, 16'h2022, 16'h00B7, 16'h221A, 16'h207F, 16'h00B2, 16'h00B3, 16'h00AF
   };

endpackage

FILE: design/codepage_to_utf8_crlf_core.sv
// ----------------------------------------------------------------------------
// codepage_to_utf8_crlf_core: code-page to utf-8 transcoder with lf folding
// one code-page byte per req beat in, one utf-8 byte per rsp beat out
// ----------------------------------------------------------------------------
// usage
//   req channel: text_byte plus end_of_text, one character per beat
//   rsp channel: utf8_byte with run_last on the final byte of each item and
//   text_last on the final byte of the whole text
//   csr channel: one-bit crlf_convert, always ready, write only while idle
// path: the first rsp beat of an item passes the queue, the work register and the rsp register
// throughput: the rsp side moves one byte per cycle while rsp_ready is high, so
//   an item gives 0..4 output bytes (held lf plus up to three bytes);
//   an item held back as a lone cr gives no output byte
// the front classifier takes a beat every cycle while the entry queue has
//   room; a stalled rsp side fills the queue and then drops req_ready
// reset clears the held cr, the queue, the serializer and crlf_convert
// ----------------------------------------------------------------------------
module codepage_to_utf8_crlf_core
   import ctu_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4
)
(
   input  logic       clock,
   input  logic       reset,
   // configuration
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic       csr_crlf_convert,
   // text bytes in
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_text_byte,
   input  logic       req_end_of_text,
   // utf-8 bytes out
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_utf8_byte,
   output logic       rsp_run_last,
   output logic       rsp_text_last
);

   logic             crlf_convert_ff, crlf_convert_in;
   logic             push, pop, queue_full, head_valid;
   ctu_entry_type    push_entry, head_entry;
   front_status_type front_status;

   // config register, a beat is taken every cycle
   assign csr_ready       = 1'b1;
   assign crlf_convert_in = (csr_valid && csr_ready) ? csr_crlf_convert : crlf_convert_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         crlf_convert_ff <= 1'b0;
      end else begin
         crlf_convert_ff <= crlf_convert_in;
      end
   end

   // classifier: folds line ends and decides what each beat produces
   ctu_front u_front (
      .clock           (clock),
      .reset           (reset),
      .crlf_convert    (crlf_convert_ff),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_text_byte   (req_text_byte),
      .req_end_of_text (req_end_of_text),
      .push            (push),
      .push_entry      (push_entry),
      .queue_full      (queue_full),
      .status          (front_status)
   );

   // entry queue between the two halves
   ctu_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   // encoder and serializer with the rsp output register
   ctu_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head_valid    (head_valid),
      .head_entry    (head_entry),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_utf8_byte (rsp_utf8_byte),
      .rsp_run_last  (rsp_run_last),
      .rsp_text_last (rsp_text_last)
   );

   // end of text always closes a run
   a_text_last_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_text_last |-> rsp_run_last)
      else $error("text_last without run_last");

   // the end of a text never leaves a cr held
   a_eot_clears_cr: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_end_of_text |=> !front_status.held_cr)
      else $error("cr held past end of text");

   // a cr is held only after a cr beat with folding on
   a_cr_hold_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(front_status.held_cr) |->
         $past(req_valid && req_ready && req_text_byte == CH_CR && crlf_convert_ff))
      else $error("cr held without cause");

endmodule

FILE: design/ctu_front.sv
// ----------------------------------------------------------------------------
// ctu_front: input classifier
// accepts text bytes, folds line ends and tracks a held cr
// ----------------------------------------------------------------------------
module ctu_front
   import ctu_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             crlf_convert,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [7:0]       req_text_byte,
   input  logic             req_end_of_text,
   output logic             push,
   output ctu_entry_type    push_entry,
   input  logic             queue_full,
   output front_status_type status
);

   logic          held_cr_ff;
   logic          held_cr_in;
   logic          accept;
   logic          hold_next;
   ctu_entry_type entry;

   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;

   always_comb begin
      entry.pre_lf = held_cr_ff;
      entry.kind   = BODY_NONE;
      entry.value  = req_text_byte;
      entry.eot    = req_end_of_text;
      hold_next    = 1'b0;
      if (held_cr_ff && crlf_convert && req_text_byte == CH_LF) begin
         entry.kind = BODY_NONE;      // cr lf pair, the held cr gives the one lf
      end else if (crlf_convert && req_text_byte == CH_LF) begin
         entry.kind = BODY_BYTE;
      end else if (crlf_convert && req_text_byte == CH_CR) begin
         if (req_end_of_text) begin
            entry.kind  = BODY_BYTE;
            entry.value = CH_LF;
         end else begin
            hold_next = 1'b1;
         end
      end else if (!req_text_byte[7]) begin
         entry.kind = BODY_BYTE;
      end else begin
         entry.kind = BODY_LOOKUP;
      end
   end

   assign held_cr_in     = accept ? hold_next : held_cr_ff;
   assign push           = accept && (entry.pre_lf || entry.kind != BODY_NONE);
   assign push_entry     = entry;
   assign status.held_cr = held_cr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         held_cr_ff <= 1'b0;
      end else begin
         held_cr_ff <= held_cr_in;
      end
   end

endmodule

FILE: design/ctu_queue.sv
// ----------------------------------------------------------------------------
// ctu_queue: small entry queue
// decouples the classifier from the byte serializer
// ----------------------------------------------------------------------------
module ctu_queue
   import ctu_pkg::*;
#(
   parameter int DEPTH = 4
)
(
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  ctu_entry_type push_entry,
   output logic          full,
   input  logic          pop,
   output logic          head_valid,
   output ctu_entry_type head_entry
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   ctu_entry_type     slots_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push, do_pop;

   assign full       = count_ff == CNT_W'(DEPTH);
   assign head_valid = count_ff != '0;
   assign head_entry = slots_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

FILE: design/ctu_back.sv
// ----------------------------------------------------------------------------
// ctu_back: utf-8 encoder and byte serializer
// expands queue entries into bytes and drives the result register
// ----------------------------------------------------------------------------
module ctu_back
   import ctu_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          head_valid,
   input  ctu_entry_type head_entry,
   output logic          pop,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output logic [7:0]    rsp_utf8_byte,
   output logic          rsp_run_last,
   output logic          rsp_text_last
);

   logic        work_valid_ff, work_valid_in;
   logic [7:0]  work_bytes_ff [4];
   logic [7:0]  work_bytes_in [4];
   logic [2:0]  work_count_ff, work_count_in;
   logic [1:0]  work_idx_ff, work_idx_in;
   logic        work_eot_ff, work_eot_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  rsp_byte_ff, rsp_byte_in;
   logic        rsp_run_last_ff, rsp_run_last_in;
   logic        rsp_text_last_ff, rsp_text_last_in;

   logic        out_free, move, work_last, load;
   logic [15:0] cp;
   logic [7:0]  body [3];
   logic [1:0]  body_n;

   // utf-8 form of the entry body
   always_comb begin
      cp      = CODE_POINTS[head_entry.value[6:0]];
      body[0] = head_entry.value;
      body[1] = 8'h00;
      body[2] = 8'h00;
      body_n  = 2'd0;
      case (head_entry.kind)
         BODY_NONE: begin
            body_n = 2'd0;
         end
         BODY_BYTE: begin
            body_n = 2'd1;
         end
         BODY_LOOKUP: begin
            if (cp < 16'h0080) begin
               body[0] = cp[7:0];
               body_n  = 2'd1;
            end else if (cp < 16'h0800) begin
               body[0] = {3'b110, cp[10:6]};
               body[1] = {2'b10, cp[5:0]};
               body_n  = 2'd2;
            end else begin
               body[0] = {4'b1110, cp[15:12]};
               body[1] = {2'b10, cp[11:6]};
               body[2] = {2'b10, cp[5:0]};
               body_n  = 2'd3;
            end
         end
         default: begin
            body_n = 2'd0;
         end
      endcase
   end

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign move      = work_valid_ff && out_free;
   assign work_last = ({1'b0, work_idx_ff} + 3'd1) == work_count_ff;
   assign load      = head_valid && (!work_valid_ff || (move && work_last));
   assign pop       = load;

   always_comb begin
      work_valid_in = work_valid_ff;
      work_bytes_in = work_bytes_ff;
      work_count_in = work_count_ff;
      work_idx_in   = work_idx_ff;
      work_eot_in   = work_eot_ff;
      if (load) begin
         work_valid_in = 1'b1;
         work_idx_in   = 2'd0;
         work_eot_in   = head_entry.eot;
         if (head_entry.pre_lf) begin
            work_bytes_in[0] = CH_LF;
            work_bytes_in[1] = body[0];
            work_bytes_in[2] = body[1];
            work_bytes_in[3] = body[2];
            work_count_in    = {1'b0, body_n} + 3'd1;
         end else begin
            work_bytes_in[0] = body[0];
            work_bytes_in[1] = body[1];
            work_bytes_in[2] = body[2];
            work_bytes_in[3] = 8'h00;
            work_count_in    = {1'b0, body_n};
         end
      end else if (move && work_last) begin
         work_valid_in = 1'b0;
      end else if (move) begin
         work_idx_in = work_idx_ff + 2'd1;
      end
   end

   always_comb begin
      rsp_valid_in     = rsp_valid_ff && !rsp_ready;
      rsp_byte_in      = rsp_byte_ff;
      rsp_run_last_in  = rsp_run_last_ff;
      rsp_text_last_in = rsp_text_last_ff;
      if (move) begin
         rsp_valid_in     = 1'b1;
         rsp_byte_in      = work_bytes_ff[work_idx_ff];
         rsp_run_last_in  = work_last;
         rsp_text_last_in = work_last && work_eot_ff;
      end
   end

   always_ff @(posedge clock) begin
      work_bytes_ff    <= work_bytes_in;
      work_count_ff    <= work_count_in;
      work_idx_ff      <= work_idx_in;
      work_eot_ff      <= work_eot_in;
      rsp_byte_ff      <= rsp_byte_in;
      rsp_run_last_ff  <= rsp_run_last_in;
      rsp_text_last_ff <= rsp_text_last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         work_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         work_valid_ff <= work_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_utf8_byte = rsp_byte_ff;
   assign rsp_run_last  = rsp_run_last_ff;
   assign rsp_text_last = rsp_text_last_ff;

endmodule

FILE: tb/codepage_to_utf8_crlf_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// codepage_to_utf8_crlf_core_test: self-checking bench of the utf-8 transcoder
// drives code-page text bytes with random gaps, predicts every utf-8 beat and
// checks it field by field, switching line folding between phases
// ----------------------------------------------------------------------------
module codepage_to_utf8_crlf_core_test
   import ctu_pkg::*;
();

   localparam int CYCLE_LIMIT  = 200000;
   localparam int LONG_HOLD    = 100;   // cycles the receiver refuses beats once
   localparam int IDLE_SETTLE  = 6;     // lets the queue, work and rsp registers settle
   localparam int RANDOM_ITEMS = 18;    // per random phase
   localparam int MAX_REPORTS  = 10;

   // code points of the upper half of the code page, kept apart from the design
   localparam logic [15:0] UPPER_CODE_POINTS [0:127] = '{
      16'h00C7, 16'h00FC, 16'h00E9, 16'h00E2, 16'h00E4, 16'h00E0, 16'h00E5, 16'h00E7,
      16'h00EA, 16'h00EB, 16'h00E8, 16'h00EF, 16'h00EE, 16'h00EC, 16'h00C4, 16'h00C5,
      16'h00C9, 16'h00E6, 16'h00C6, 16'h00F4, 16'h00F6, 16'h00F2, 16'h00FB, 16'h00F9,
      16'h00FF, 16'h00D6, 16'h00DC, 16'h00A2, 16'h00A3, 16'h00A5, 16'h00DF, 16'h0192,
      16'h00E1, 16'h00ED, 16'h00F3, 16'h00FA, 16'h00F1, 16'h00D1, 16'h00AA, 16'h00BA,
      16'h00BF, 16'h2310, 16'h00AC, 16'h00BD, 16'h00BC, 16'h00A1, 16'h00AB, 16'h00BB,
      16'h00E3, 16'h00F5, 16'h00D8, 16'h00F8, 16'h0153, 16'h0152, 16'h00C0, 16'h00C3,
      16'h00D5, 16'h00A8, 16'h00B4, 16'h2020, 16'h00B6, 16'h00A9, 16'h00AE, 16'h2122,
      16'h0133, 16'h0132, 16'h005F, 16'h005F, 16'h005F, 16'h005F, 16'h005F, 16'h005F,
      16'h005F, 16'h005F, 16'h005F, 16'h005F, 16'h005F, 16'h005F, 16'h005F, 16'h005F,
      16'h005F, 16'h005F, 16'h005F, 16'h005F, 16'h005F, 16'h005F, 16'h005F, 16'h005F,
      16'h005F, 16'h005F, 16'h005F, 16'h005F, 16'h005F, 16'h00A7, 16'h2227, 16'h221E,
      16'h03B1, 16'h03B2, 16'h0393, 16'h03C0, 16'h03A3, 16'h03C3, 16'h00B5, 16'h03C4,
      16'h03A6, 16'h0398, 16'h03A9, 16'h03B4, 16'h222E, 16'h03C6, 16'h2208, 16'h2229,
      16'h2261, 16'h00B1, 16'h2265, 16'h2264, 16'h2320, 16'h2321, 16'h00F7, 16'h2248,
      16'h00B0, 16'h2022, 16'h00B7, 16'h221A, 16'h207F, 16'h00B2, 16'h00B3, 16'h00AF
   };

   typedef struct packed {
      logic [7:0] text_byte;
      logic       eot;
   } text_item_type;

   typedef struct packed {
      logic [7:0] utf8_byte;
      logic       run_last;
      logic       text_last;
   } utf8_beat_type;

   // dut ports, every input known from time zero
   logic       clock            = 1'b0;
   logic       reset            = 1'b1;
   logic       csr_valid        = 1'b0;
   logic       csr_ready;
   logic       csr_crlf_convert = 1'b0;
   logic       req_valid        = 1'b0;
   logic       req_ready;
   logic [7:0] req_text_byte    = 8'h00;
   logic       req_end_of_text  = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready        = 1'b0;
   logic [7:0] rsp_utf8_byte;
   logic       rsp_run_last;
   logic       rsp_text_last;

   // stimulus and scoreboard
   text_item_type text_pending [$];
   utf8_beat_type utf8_expected [$];

   // shadow of the block: folding switch and held carriage return
   logic fold_on   = 1'b0;
   logic cr_waits  = 1'b0;

   // knobs set by the sequencer, read by the driver and the receiver
   bit req_gaps_on  = 1'b0;
   bit rsp_gaps_on  = 1'b0;
   bit stall_armed  = 1'b0;
   bit stall_done   = 1'b0;

   int cycle_count  = 0;
   int fault_count  = 0;
   int items_in     = 0;
   int beats_out    = 0;
   int texts_done   = 0;
   int held_flushes = 0;
   int csr_writes   = 0;

   codepage_to_utf8_crlf_core dut (
      .clock            (clock),
      .reset            (reset),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_crlf_convert (csr_crlf_convert),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_text_byte    (req_text_byte),
      .req_end_of_text  (req_end_of_text),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_utf8_byte    (rsp_utf8_byte),
      .rsp_run_last     (rsp_run_last),
      .rsp_text_last    (rsp_text_last)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // mostly back to back, some short gaps, now and then a long one
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 19);
      if (roll < 12) return 0;
      if (roll < 18) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // expected utf-8 beats of one accepted text byte, updates the held cr
   function automatic void predict_utf8(input logic [7:0] text_byte, input logic eot);
      logic [7:0]  seq [$];
      logic [15:0] cp;
      bit          pair_eaten;
      pair_eaten = 1'b0;

      // a held cr always comes out as lf first; an lf right behind it is eaten while folding is on
      if (cr_waits) begin
         cr_waits = 1'b0;
         held_flushes++;
         seq.push_back(CH_LF);
         if (fold_on && text_byte == CH_LF) pair_eaten = 1'b1;
      end

      if (!pair_eaten) begin
         if (fold_on && text_byte == CH_LF) begin
            seq.push_back(CH_LF);
         end else if (fold_on && text_byte == CH_CR) begin
            // cr on the last byte of a text cannot wait for a partner
            if (eot) seq.push_back(CH_LF);
            else cr_waits = 1'b1;
         end else if (text_byte < 8'h80) begin
            seq.push_back(text_byte);
         end else begin
            cp = UPPER_CODE_POINTS[text_byte[6:0]];
            if (cp < 16'h0080) begin
               seq.push_back(cp[7:0]);
            end else if (cp < 16'h0800) begin
               seq.push_back(8'hC0 | 8'(cp >> 6));
               seq.push_back(8'h80 | 8'(cp & 16'h003F));
            end else begin
               seq.push_back(8'hE0 | 8'((cp >> 12) & 16'h000F));
               seq.push_back(8'h80 | 8'((cp >> 6) & 16'h003F));
               seq.push_back(8'h80 | 8'(cp & 16'h003F));
            end
         end
      end

      foreach (seq[k]) begin
         utf8_expected.push_back('{utf8_byte: seq[k],
                                   run_last:  (k == seq.size() - 1),
                                   text_last: (k == seq.size() - 1) && eot});
      end
      if (eot) cr_waits = 1'b0;
   endfunction

   // req driver: one beat at a time from the pending queue, random gaps after each while gaps are on
   always @(posedge clock) begin : req_driver
      text_item_type item;
      logic          next_valid;
      int            gap_left;
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
      end else begin
         next_valid = req_valid;
         if (req_valid && req_ready) begin
            predict_utf8(req_text_byte, req_end_of_text);
            items_in++;
            if (req_end_of_text) texts_done++;
            next_valid = 1'b0;
         end
         // only one assignment to req_valid per edge, so back-to-back beats keep it high
         if (!next_valid) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (text_pending.size() > 0) begin
               item = text_pending.pop_front();
               req_text_byte   <= item.text_byte;
               req_end_of_text <= item.eot;
               next_valid = 1'b1;
               gap_left = req_gaps_on ? pick_gap() : 0;
            end
         end
         req_valid <= next_valid;
      end
   end

   // rsp receiver: random back pressure plus one long hold to fill the block
   always @(posedge clock) begin : rsp_receiver
      int hold_left;
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_left = 0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (stall_armed && !stall_done) begin
         stall_done = 1'b1;
         hold_left = LONG_HOLD - 1;
         rsp_ready <= 1'b0;
      end else if (rsp_gaps_on && $urandom_range(0, 3) == 0) begin
         hold_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(0, 2);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // rsp monitor: every accepted beat against the oldest expectation
   always @(posedge clock) begin : rsp_monitor
      utf8_beat_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         beats_out++;
         if (utf8_expected.size() == 0) begin
            fault_count++;
            if (fault_count <= MAX_REPORTS)
               $display("%0t: unexpected beat byte=%02h run_last=%b text_last=%b",
                        $time, rsp_utf8_byte, rsp_run_last, rsp_text_last);
         end else begin
            want = utf8_expected.pop_front();
            if (rsp_utf8_byte !== want.utf8_byte || rsp_run_last !== want.run_last ||
                rsp_text_last !== want.text_last) begin
               fault_count++;
               if (fault_count <= MAX_REPORTS)
                  $display("%0t: mismatch byte/run_last/text_last exp %02h/%b/%b got %02h/%b/%b",
                           $time, want.utf8_byte, want.run_last, want.text_last,
                           rsp_utf8_byte, rsp_run_last, rsp_text_last);
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d beats still expected",
                  cycle_count, utf8_expected.size());
         $display("Test completed with failures");
         $finish;
      end
   end

   task automatic push_text(input logic [7:0] text_byte, input logic eot);
      text_pending.push_back('{text_byte: text_byte, eot: eot});
   endtask

   // wait until every byte is sent and every beat is back, then let the pipe settle
   task automatic wait_drained();
      do @(negedge clock);
      while (text_pending.size() != 0 || req_valid || utf8_expected.size() != 0);
      repeat (IDLE_SETTLE) @(negedge clock);
   endtask

   task automatic write_fold(input logic value);
      @(posedge clock);
      csr_valid        <= 1'b1;
      csr_crlf_convert <= value;
      do @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
      fold_on = value;
      csr_writes++;
      @(negedge clock);
   endtask

   // random text: line ends, ascii and upper half mixed, texts of random length
   task automatic push_random_text(input int count);
      int         roll;
      logic [7:0] text_byte;
      for (int i = 0; i < count; i++) begin
         roll = $urandom_range(0, 9);
         case (roll)
            0, 1:    text_byte = CH_CR;
            2:       text_byte = CH_LF;
            3, 4:    text_byte = 8'($urandom_range(1, 127));
            9:       text_byte = 8'($urandom_range(1, 255));
            default: text_byte = 8'($urandom_range(128, 255));
         endcase
         push_text(text_byte, (i == count - 1) || ($urandom_range(0, 9) == 0));
      end
   endtask

   // sequencer: directed phases first, then random phases with mixed settings
   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // folding off from reset: pass-through, two- and three-byte forms
      push_text(8'h01, 1'b0);
      push_text(8'h7F, 1'b0);
      push_text(8'h80, 1'b0);          // lowest upper-half byte
      push_text(8'hA9, 1'b0);          // three-byte sequence
      push_text(8'h82, 1'b0);          // another two-byte form
      push_text(CH_CR, 1'b0);          // cr and lf untouched while folding is off
      push_text(CH_LF, 1'b0);
      push_text(8'hFF, 1'b1);          // highest byte ends the text
      wait_drained();

      // folding on: lone lf, cr lf pair, cr before other bytes, cr cr, cr at end
      write_fold(1'b1);
      req_gaps_on = 1'b1;
      rsp_gaps_on = 1'b1;
      push_text(8'h61, 1'b0);
      push_text(CH_LF, 1'b0);
      push_text(CH_CR, 1'b0);
      push_text(CH_LF, 1'b0);
      push_text(CH_CR, 1'b0);
      push_text(8'h62, 1'b0);
      push_text(CH_CR, 1'b0);
      push_text(CH_CR, 1'b0);
      push_text(8'hEC, 1'b0);          // held lf plus three bytes, four beats
      push_text(CH_CR, 1'b1);          // final cr is not held
      push_text(CH_CR, 1'b0);
      push_text(CH_LF, 1'b1);
      push_text(CH_CR, 1'b0);          // phase ends with a cr held
      wait_drained();

      // folding switched off with a cr still held: it still comes out as lf
      write_fold(1'b0);
      push_text(8'h78, 1'b0);
      push_text(CH_CR, 1'b0);
      push_text(8'h96, 1'b1);
      wait_drained();

      for (int phase = 0; phase < 5; phase++) begin
         write_fold(phase == 0 ? 1'b1 : phase == 1 ? 1'b0 : 1'($urandom_range(0, 1)));
         // one phase runs both sides flat out
         req_gaps_on = (phase != 2);
         rsp_gaps_on = (phase != 2);
         push_random_text(RANDOM_ITEMS);
         // long receiver hold while the sender keeps offering beats
         if (phase == 3) stall_armed = 1'b1;
         wait_drained();
      end

      repeat (20) @(negedge clock);
      if (utf8_expected.size() != 0) begin
         fault_count++;
         $display("%0d expected beats never arrived", utf8_expected.size());
      end

      $display("covered %0d text bytes in %0d texts, %0d utf-8 beats, %0d held cr flushes",
               items_in, texts_done, beats_out, held_flushes);
      $display("with %0d folding switches, random gaps on both sides and one long rsp hold",
               csr_writes);
      if (fault_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("%0d failures", fault_count);
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
